// ===== hw/rtl/pipt_pkg.sv =====
// Package for the point-in-polygon core: transfer structs, store sizing,
// turn codes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pipt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MIN_POLY     = 3;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  localparam logic [1:0] TURN_COL = 2'd0;
  localparam logic [1:0] TURN_CW  = 2'd1;
  localparam logic [1:0] TURN_CCW = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
  } in_t;

  typedef struct packed {
    logic inside_res;
    logic too_few_vertices;
  } out_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_first;
    logic              pt_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_poly;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/point_in_polygon_test_core.sv =====
// Top level of the point-in-polygon core: controller plus datapath.
// Depends on pipt_pkg, pipt_ctrl and pipt_dp.
//
//   channel   ports              transfer when
//   input     start, busy, in_i  start high and busy low at a rising edge
//   result    valid_o, res_o     valid_o high (one cycle, no stall)
//
// Loads (start, append, unused opcode) leave the core idle; busy stays low.
// A test with fewer than three vertices answers in the cycle after the transfer.
// A test with n vertices reads the vertex memory n+1 times (one port read a
// cycle) and drains a three-stage edge pipeline.
// rst_ni is asynchronous, active low; the vertex memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test_core import pipt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_i,
  output out_t      res_o,
  output logic      valid_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pipt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .res_o   (res_o),
    .valid_o (valid_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  pipt_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pipt_dp.sv =====
// Datapath: vertex memory, edge pipeline (products, turn signs) and the
// crossing parity / on-edge accumulators. Depends on pipt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pipt_dp import pipt_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire in_t     in_i,
  input  wire dp_cmd_t cmd_i,
  output dp_sts_t      sts_o
);

  logic [31:0] mem_q [MAX_VERTICES];
  logic [31:0] rd_q;
  logic        v1_q, first1_q, v2_q;
  logic signed [15:0] px_q, py_q, ax_q, ay_q;
  logic signed [15:0] bx, by;
  logic signed [16:0] dy_ab, dx_ab, dpx, dpy;
  logic signed [17:0] drx;
  logic signed [33:0] m1, m3, m1_q, m3_q;
  logic signed [34:0] m2, m2_q;
  logic signed [35:0] v1, v2;
  logic [1:0] o1, o2, o3, o4, o3_q, o4_q;
  logic box, t3, t4, box_q, t3_q, t4_q;
  logic meet;
  logic hit_q, hitval_q, par_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= {in_i.coord_x, in_i.coord_y};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cmd_i.rd_addr];
    end
  end

  assign bx    = $signed(rd_q[31:16]);
  assign by    = $signed(rd_q[15:0]);
  assign dy_ab = {by[15], by} - {ay_q[15], ay_q};
  assign dx_ab = {bx[15], bx} - {ax_q[15], ax_q};
  assign dpx   = {px_q[15], px_q} - {bx[15], bx};
  assign dpy   = {py_q[15], py_q} - {by[15], by};
  assign drx   = 18'sd65536 - {{2{bx[15]}}, bx};
  assign m1    = dy_ab * dpx;
  assign m2    = dy_ab * drx;
  assign m3    = dx_ab * dpy;

  always_comb begin
    box = ((px_q <= ax_q) || (px_q <= bx)) && ((px_q >= ax_q) || (px_q >= bx)) &&
          ((py_q <= ay_q) || (py_q <= by)) && ((py_q >= ay_q) || (py_q >= by));
    t3  = (ay_q == py_q) && (ax_q >= px_q);
    t4  = (by == py_q) && (bx >= px_q);
    if (ay_q == py_q) begin
      o3 = TURN_COL;
    end else if (ay_q < py_q) begin
      o3 = TURN_CW;
    end else begin
      o3 = TURN_CCW;
    end
    if (by == py_q) begin
      o4 = TURN_COL;
    end else if (by < py_q) begin
      o4 = TURN_CW;
    end else begin
      o4 = TURN_CCW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_load) begin
      px_q <= in_i.coord_x;
      py_q <= in_i.coord_y;
    end
    if (v1_q) begin
      ax_q <= bx;
      ay_q <= by;
    end
    m1_q  <= m1;
    m2_q  <= m2;
    m3_q  <= m3;
    o3_q  <= o3;
    o4_q  <= o4;
    box_q <= box;
    t3_q  <= t3;
    t4_q  <= t4;
  end

  assign v1 = {{2{m1_q[33]}}, m1_q} - {{2{m3_q[33]}}, m3_q};
  assign v2 = {m2_q[34], m2_q} - {{2{m3_q[33]}}, m3_q};

  always_comb begin
    if (v1 == '0) begin
      o1 = TURN_COL;
    end else if (!v1[35]) begin
      o1 = TURN_CW;
    end else begin
      o1 = TURN_CCW;
    end
    if (v2 == '0) begin
      o2 = TURN_COL;
    end else if (!v2[35]) begin
      o2 = TURN_CW;
    end else begin
      o2 = TURN_CCW;
    end
    meet = ((o1 != o2) && (o3_q != o4_q)) || ((o1 == TURN_COL) && box_q) || t3_q || t4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      first1_q <= 1'b0;
      v2_q     <= 1'b0;
      hit_q    <= 1'b0;
      hitval_q <= 1'b0;
      par_q    <= 1'b0;
    end else begin
      v1_q     <= cmd_i.rd_en;
      first1_q <= cmd_i.rd_first;
      v2_q     <= v1_q && !first1_q;
      if (cmd_i.pt_load) begin
        hit_q    <= 1'b0;
        hitval_q <= 1'b0;
        par_q    <= 1'b0;
      end else if (v2_q && !hit_q && meet) begin
        if (o1 == TURN_COL) begin
          hit_q    <= 1'b1;
          hitval_q <= box_q;
        end else begin
          par_q <= !par_q;
        end
      end
    end
  end

  assign sts_o.in_poly = hit_q ? hitval_q : par_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pipt_ctrl.sv =====
// Controller: accepts transfers, keeps the vertex count, walks the edges
// and registers the result strobe. Depends on pipt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pipt_ctrl import pipt_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire in_t     in_i,
  output out_t         res_o,
  output logic         valid_o,
  output dp_cmd_t      cmd_o,
  input  wire dp_sts_t sts_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             drn_q, drn_d;
  logic             valid_d;
  out_t             res_q, res_d;
  logic             acc;
  logic             last;

  assign acc  = start && (state_q == S_IDLE);
  assign last = (idx_q == cnt_q);
  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    drn_d    = drn_q;
    valid_d  = 1'b0;
    res_d    = res_q;
    cmd_o    = '0;
    cmd_o.rd_addr = last ? '0 : idx_q[ADDR_W-1:0];
    cmd_o.rd_first = (idx_q == '0);
    cmd_o.wr_addr = (in_i.opcode == OP_START) ? '0 : cnt_q[ADDR_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (in_i.opcode)
            OP_START: begin
              cmd_o.wr_en = 1'b1;
              cnt_d       = CNT_W'(1);
            end
            OP_APPEND: begin
              if (cnt_q < CNT_W'(MAX_VERTICES)) begin
                cmd_o.wr_en = 1'b1;
                cnt_d       = cnt_q + 1'b1;
              end
            end
            OP_TEST: begin
              if (cnt_q < CNT_W'(MIN_POLY)) begin
                valid_d = 1'b1;
                res_d   = '{inside_res: 1'b0, too_few_vertices: 1'b1};
              end else begin
                cmd_o.pt_load = 1'b1;
                idx_d         = '0;
                state_d       = S_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RUN: begin
        cmd_o.rd_en = 1'b1;
        idx_d       = idx_q + 1'b1;
        if (last) begin
          drn_d   = 1'b0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drn_d = 1'b1;
        if (drn_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        valid_d = 1'b1;
        res_d   = '{inside_res: sts_i.in_poly, too_few_vertices: 1'b0};
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      drn_q   <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      drn_q   <= drn_d;
      valid_o <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire
